### rtl/gcib_pkg.sv
// shared constants and elaboration-time functions for the great-circle bearing pipeline
package gcib_pkg;

    localparam int CORDIC_STEPS_DEF    = 20;
    localparam int ANGLE_FRAC_BITS_DEF = 24;

    // one turn in 1e-7 degree
    localparam logic signed [34:0] TURN_E7 = 35'sd3600000000;

    // turns conversion: q32 = floor((t * 2^22 + DIV_BIAS) / DIV_D)
    localparam logic [21:0] DIV_D = 22'd3515625;
    localparam logic [21:0] DIV_BIAS = 22'd1757812;
    // floor(2^54 / DIV_D) = 2^32 + RECIP_LO
    localparam logic [29:0] RECIP_LO = 30'd829128280;

    localparam logic [31:0] HALF_TURN = 32'h8000_0000;
    localparam logic [15:0] CENT_TURN = 16'd36000;

    // atan(2^-i) in q32 turns, rounded to nearest
    function automatic logic [31:0] atan_rom(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h2000_0000;
            1:  v = 32'h12E4_051E;
            2:  v = 32'h09FB_385B;
            3:  v = 32'h0511_11D4;
            4:  v = 32'h028B_0D43;
            5:  v = 32'h0145_D7E1;
            6:  v = 32'h00A2_F61E;
            7:  v = 32'h0051_7C55;
            8:  v = 32'h0028_BE53;
            9:  v = 32'h0014_5F2F;
            10: v = 32'h000A_2F98;
            11: v = 32'h0005_17CC;
            12: v = 32'h0002_8BE6;
            13: v = 32'h0001_45F3;
            14: v = 32'h0000_A2FA;
            15: v = 32'h0000_517D;
            16: v = 32'h0000_28BE;
            17: v = 32'h0000_145F;
            18: v = 32'h0000_0A30;
            19: v = 32'h0000_0518;
            20: v = 32'h0000_028C;
            21: v = 32'h0000_0146;
            22: v = 32'h0000_00A3;
            23: v = 32'h0000_0051;
            24: v = 32'h0000_0029;
            25: v = 32'h0000_0014;
            26: v = 32'h0000_000A;
            27: v = 32'h0000_0005;
            28: v = 32'h0000_0003;
            29: v = 32'h0000_0001;
            30: v = 32'h0000_0001;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

    // shift-subtract long division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int k = 63; k >= 0; k--) begin
            r = {r[62:0], n[k]};
            if (r >= d) begin
                r = r - d;
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    // starting x of a rotation: 1/prod(sqrt(1+4^-i)) with frac fraction bits
    function automatic logic [63:0] gain_start(input int steps, input int frac);
        logic [63:0] p;
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        p = 64'd1 << 62;
        for (int i = 0; i < steps; i++) begin
            p = p - udiv64(p, (64'd1 << (2 * i)) + 64'd1);
        end
        n = p;
        r = '0;
        b = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (b > n) b = b >> 2;
        end
        for (int k = 0; k < 32; k++) begin
            if (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return (r + (64'd1 << (30 - frac))) >> (31 - frac);
    endfunction

endpackage

### rtl/great_circle_initial_bearing.sv
// great-circle initial bearing, fully pipelined row of cordic cells
// throughput: one position pair per cycle unless a finished result waits on i_ready;
//   a four-stage reciprocal conversion per lane and two rows of CORDIC_STEPS cordic
//   stages each take one step of work per cycle
// reset: synchronous active-low i_rst_n clears all valid bits; payload is not reset
module great_circle_initial_bearing import gcib_pkg::*; #(
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [30:0] i_start_lat,
    input  logic signed [31:0] i_start_lon,
    input  logic signed [30:0] i_end_lat,
    input  logic signed [31:0] i_end_lon,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_bearing_centideg
);

    // value width for sine, cosine and products, and for the vectoring row
    localparam int W   = ANGLE_FRAC_BITS + 3;
    localparam int VW  = ANGLE_FRAC_BITS + 4;
    localparam int PW  = 2 * W;
    localparam int N   = CORDIC_STEPS;
    localparam int LAT = 14 + 2 * N;

    localparam logic [63:0] GAIN_FULL = gain_start(CORDIC_STEPS, ANGLE_FRAC_BITS);
    localparam logic signed [W-1:0] GAIN = $signed(GAIN_FULL[W-1:0]);
    localparam logic signed [PW-1:0] MUL_RND = {{(PW-1){1'b0}}, 1'b1} << (ANGLE_FRAC_BITS - 1);

    // whole row advances together; stalls only when a finished result waits
    logic           en;
    logic [LAT-1:0] r_vld;

    assign en      = !r_vld[LAT-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // input registers and longitude difference
    logic signed [30:0] r_lat1;
    logic signed [30:0] r_lat2;
    logic signed [32:0] r_dlon;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lat1 <= i_start_lat;
            r_lat2 <= i_end_lat;
            r_dlon <= {i_end_lon[31], i_end_lon} - {i_start_lon[31], i_start_lon};
        end
    end

    // reduce into one turn of 1e-7 degree
    logic signed [34:0] ext_lat1;
    logic signed [34:0] ext_lat2;
    logic signed [34:0] ext_dlon;
    logic signed [34:0] red_lat1;
    logic signed [34:0] red_lat2;
    logic signed [34:0] red_dlon;
    logic [31:0]        r_turn_in [3];

    always_comb begin
        ext_lat1 = 35'(r_lat1);
        ext_lat2 = 35'(r_lat2);
        ext_dlon = 35'(r_dlon);
        red_lat1 = ext_lat1[34] ? ext_lat1 + TURN_E7 : ext_lat1;
        red_lat2 = ext_lat2[34] ? ext_lat2 + TURN_E7 : ext_lat2;
        if (ext_dlon < -TURN_E7) begin
            red_dlon = ext_dlon + TURN_E7 + TURN_E7;
        end else if (ext_dlon[34]) begin
            red_dlon = ext_dlon + TURN_E7;
        end else if (ext_dlon >= TURN_E7) begin
            red_dlon = ext_dlon - TURN_E7;
        end else begin
            red_dlon = ext_dlon;
        end
    end

    // lanes: 0 start latitude, 1 end latitude, 2 longitude difference
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_turn_in[0] <= red_lat1[31:0];
            r_turn_in[1] <= red_lat2[31:0];
            r_turn_in[2] <= red_dlon[31:0];
        end
    end

    // q32 binary angle per lane, converted from the reduced value by the division cell
    logic [31:0] conv_q [3];

    // rotation row signals
    logic signed [W-1:0] rot_x   [3][N+1];
    logic signed [W-1:0] rot_y   [3][N+1];
    logic signed [32:0]  rot_z   [3][N+1];
    logic                rot_neg [3][N+1];

    // fold angles in the second and third quadrant by half a turn
    logic [31:0] fold_a   [3];
    logic        fold_neg [3];

    for (genvar l = 0; l < 3; l++) begin : g_lane
        gcib_div_cell u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_t   (r_turn_in[l]),
            .o_q   (conv_q[l])
        );

        always_comb begin
            fold_neg[l] = (conv_q[l][31:30] == 2'b01) ||
                          (conv_q[l][31:30] == 2'b10);
            fold_a[l]   = fold_neg[l] ? conv_q[l] - HALF_TURN
                                      : conv_q[l];
        end

        logic signed [W-1:0] r_fx;
        logic signed [32:0]  r_fz;
        logic                r_fneg;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_fx   <= GAIN;
                r_fz   <= {fold_a[l][31], fold_a[l]};
                r_fneg <= fold_neg[l];
            end
        end

        assign rot_x[l][0]   = r_fx;
        assign rot_y[l][0]   = '0;
        assign rot_z[l][0]   = r_fz;
        assign rot_neg[l][0] = r_fneg;

        for (genvar k = 0; k < N; k++) begin : g_rot
            gcib_rot_cell #(
                .W    (W),
                .STEP (k)
            ) u_rot (
                .i_clk (i_clk),
                .i_en  (en),
                .i_x   (rot_x[l][k]),
                .i_y   (rot_y[l][k]),
                .i_z   (rot_z[l][k]),
                .i_neg (rot_neg[l][k]),
                .o_x   (rot_x[l][k+1]),
                .o_y   (rot_y[l][k+1]),
                .o_z   (rot_z[l][k+1]),
                .o_neg (rot_neg[l][k+1])
            );
        end
    end

    // undo the half-turn fold: cosine and sine per lane
    logic signed [W-1:0] r_cos [3];
    logic signed [W-1:0] r_sin [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                r_cos[l] <= rot_neg[l][N] ? -rot_x[l][N] : rot_x[l][N];
                r_sin[l] <= rot_neg[l][N] ? -rot_y[l][N] : rot_y[l][N];
            end
        end
    end

    // first products: sd*c2, c1*s2, c2*cd, each rounded half up
    logic signed [PW-1:0] prod_num;
    logic signed [PW-1:0] prod_p1;
    logic signed [PW-1:0] prod_t;
    logic signed [PW-1:0] prod_p2;
    logic signed [PW-1:0] sh_num;
    logic signed [PW-1:0] sh_p1;
    logic signed [PW-1:0] sh_t;
    logic signed [PW-1:0] sh_p2;
    logic signed [W-1:0]  r_m1_num;
    logic signed [W-1:0]  r_m1_p1;
    logic signed [W-1:0]  r_m1_t;
    logic signed [W-1:0]  r_m1_s1;
    logic signed [W-1:0]  r_m2_num;
    logic signed [W-1:0]  r_m2_p1;
    logic signed [W-1:0]  r_m2_p2;

    always_comb begin
        prod_num = PW'(r_sin[2]) * PW'(r_cos[1]);
        prod_p1  = PW'(r_cos[0]) * PW'(r_sin[1]);
        prod_t   = PW'(r_cos[1]) * PW'(r_cos[2]);
        sh_num   = (prod_num + MUL_RND) >>> ANGLE_FRAC_BITS;
        sh_p1    = (prod_p1 + MUL_RND) >>> ANGLE_FRAC_BITS;
        sh_t     = (prod_t + MUL_RND) >>> ANGLE_FRAC_BITS;
        prod_p2  = PW'(r_m1_s1) * PW'(r_m1_t);
        sh_p2    = (prod_p2 + MUL_RND) >>> ANGLE_FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_num <= sh_num[W-1:0];
            r_m1_p1  <= sh_p1[W-1:0];
            r_m1_t   <= sh_t[W-1:0];
            r_m1_s1  <= r_sin[0];
            // second product: s1 * (c2*cd)
            r_m2_num <= r_m1_num;
            r_m2_p1  <= r_m1_p1;
            r_m2_p2  <= sh_p2[W-1:0];
        end
    end

    // numerator and denominator of the arctangent
    logic signed [W-1:0] r_num;
    logic signed [W-1:0] r_den;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num <= r_m2_num;
            r_den <= r_m2_p1 - r_m2_p2;
        end
    end

    // vectoring row: negative x turned by half a turn first, zero vector flagged
    logic signed [VW-1:0] vec_x    [N+1];
    logic signed [VW-1:0] vec_y    [N+1];
    logic [31:0]          vec_z    [N+1];
    logic                 vec_zero [N+1];
    logic signed [VW-1:0] ext_num;
    logic signed [VW-1:0] ext_den;
    logic signed [VW-1:0] r_vx;
    logic signed [VW-1:0] r_vy;
    logic [31:0]          r_vz;
    logic                 r_vzero;

    assign ext_num = VW'(r_num);
    assign ext_den = VW'(r_den);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vx    <= r_den[W-1] ? -ext_den : ext_den;
            r_vy    <= r_den[W-1] ? -ext_num : ext_num;
            r_vz    <= r_den[W-1] ? HALF_TURN : '0;
            r_vzero <= (r_num == '0) && (r_den == '0);
        end
    end

    assign vec_x[0]    = r_vx;
    assign vec_y[0]    = r_vy;
    assign vec_z[0]    = r_vz;
    assign vec_zero[0] = r_vzero;

    for (genvar k = 0; k < N; k++) begin : g_vec
        gcib_vec_cell #(
            .W    (VW),
            .STEP (k)
        ) u_vec (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_x    (vec_x[k]),
            .i_y    (vec_y[k]),
            .i_z    (vec_z[k]),
            .i_zero (vec_zero[k]),
            .o_x    (vec_x[k+1]),
            .o_y    (vec_y[k+1]),
            .o_z    (vec_z[k+1]),
            .o_zero (vec_zero[k+1])
        );
    end

    // q32 turns to hundredths of a degree, rounded half up
    logic [47:0] cent_prod;
    logic [15:0] r_cent;
    logic        r_czero;
    logic [15:0] r_out;

    assign cent_prod = 48'(vec_z[N]) * 48'(CENT_TURN) + 48'(HALF_TURN);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cent  <= cent_prod[47:32];
            r_czero <= vec_zero[N];
            // zero vector and a full-turn round-up both give north
            r_out   <= (r_czero || (r_cent >= CENT_TURN)) ? '0 : r_cent;
        end
    end

    assign o_bearing_centideg = r_out;

endmodule

### rtl/gcib_div_cell.sv
// degree-to-turn conversion by reciprocal multiplication and one remainder correction
module gcib_div_cell import gcib_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_t,
    output logic [31:0] o_q
);

    // estimate t + (t*RECIP_LO >> 32) is short by zero or one;
    // the remainder lies below 2*DIV_D, so its low 23 bits settle it
    logic [61:0] n_prod;
    logic [31:0] n_q0;
    logic [22:0] n_m2;
    logic [22:0] n_rem;
    logic        n_ge;
    logic [31:0] r_t;
    logic [61:0] r_prod;
    logic [31:0] r_q0;
    logic        r_lsb;
    logic [31:0] r_q1;
    logic [22:0] r_m2;
    logic [22:0] r_nlo;
    logic [31:0] r_q;

    always_comb begin
        n_prod = {30'd0, i_t} * {32'd0, RECIP_LO};
        n_q0   = r_t + {2'b00, r_prod[61:32]};
        n_m2   = r_q0[22:0] * {1'b0, DIV_D};
        n_rem  = r_nlo - r_m2;
        n_ge   = (n_rem >= {1'b0, DIV_D});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t    <= i_t;
            r_prod <= n_prod;
            r_q0   <= n_q0;
            r_lsb  <= r_t[0];
            r_q1   <= r_q0;
            r_m2   <= n_m2;
            r_nlo  <= {r_lsb, DIV_BIAS};
            r_q    <= r_q1 + {31'd0, n_ge};
        end
    end

    assign o_q = r_q;

endmodule

### rtl/gcib_rot_cell.sv
// one cordic rotation step for sine and cosine
module gcib_rot_cell import gcib_pkg::*; #(
    parameter int W    = ANGLE_FRAC_BITS_DEF + 3,
    parameter int STEP = 0
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [W-1:0] i_x,
    input  logic signed [W-1:0] i_y,
    input  logic signed [32:0]  i_z,
    input  logic                i_neg,
    output logic signed [W-1:0] o_x,
    output logic signed [W-1:0] o_y,
    output logic signed [32:0]  o_z,
    output logic                o_neg
);

    localparam logic signed [32:0] ATAN = {1'b0, atan_rom(STEP)};

    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    logic signed [W-1:0] n_x;
    logic signed [W-1:0] n_y;
    logic signed [32:0]  n_z;
    logic signed [W-1:0] r_x;
    logic signed [W-1:0] r_y;
    logic signed [32:0]  r_z;
    logic                r_neg;

    always_comb begin
        dx = i_y >>> STEP;
        dy = i_x >>> STEP;
        if (!i_z[32]) begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_neg <= i_neg;
        end
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;
    assign o_neg = r_neg;

endmodule

### rtl/gcib_vec_cell.sv
// one cordic vectoring step for the arctangent
module gcib_vec_cell import gcib_pkg::*; #(
    parameter int W    = ANGLE_FRAC_BITS_DEF + 4,
    parameter int STEP = 0
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [W-1:0] i_x,
    input  logic signed [W-1:0] i_y,
    input  logic [31:0]         i_z,
    input  logic                i_zero,
    output logic signed [W-1:0] o_x,
    output logic signed [W-1:0] o_y,
    output logic [31:0]         o_z,
    output logic                o_zero
);

    localparam logic [31:0] ATAN = atan_rom(STEP);

    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    logic signed [W-1:0] n_x;
    logic signed [W-1:0] n_y;
    logic [31:0]         n_z;
    logic signed [W-1:0] r_x;
    logic signed [W-1:0] r_y;
    logic [31:0]         r_z;
    logic                r_zero;

    always_comb begin
        dx = i_y >>> STEP;
        dy = i_x >>> STEP;
        if (!i_y[W-1]) begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + ATAN;
        end else begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_zero <= i_zero;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_zero = r_zero;

endmodule

### tb/testbench.sv
// self-checking testbench for the great-circle initial bearing pipeline
module testbench;
    import gcib_pkg::*;

    localparam int STEPS     = 20;
    localparam int FRAC      = 24;
    localparam int LATENCY   = 14 + 2 * STEPS;
    localparam int MAX_CYCLES = 300000;
    localparam logic [63:0] TWO_PI_Q60 = 64'h6487_ED51_10B4_611A;
    localparam longint TURN_IN_E7 = 64'sd3600000000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [30:0] i_start_lat = '0;
    logic signed [31:0] i_start_lon = '0;
    logic signed [30:0] i_end_lat = '0;
    logic signed [31:0] i_end_lon = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [15:0]        o_bearing_centideg;

    great_circle_initial_bearing dut (.*);

    // angle table and rotation start value, built once at time zero
    logic [31:0] atan_q32 [STEPS];
    longint      rot_start_x;

    logic [15:0] bearing_queue [$];
    bit          failed = 1'b0;
    bit          quiet = 1'b0;
    int          cycle_count = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // bearing predictor
    // ---------------------------------------------------------------------

    // atan(2^-i) as a fraction of a turn, q32, rounded to nearest
    function automatic logic [31:0] atan_turn_entry(input int i);
        logic [63:0] rad;
        logic [63:0] r;
        logic [63:0] q;
        logic [63:0] term;
        int          k;
        rad = '0;
        q = '0;
        k = 0;
        if (i == 0) return 32'h2000_0000;
        // power series in q62 radians
        for (int e = 62 - i; e >= 0; e -= 2 * i) begin
            term = (64'd1 << e) / (2 * k + 1);
            if (k % 2) rad = rad - term;
            else rad = rad + term;
            k++;
        end
        r = rad;
        for (int n = 0; n < 31; n++) begin
            r = r << 1;
            q = q << 1;
            if (r >= TWO_PI_Q60) begin
                r = r - TWO_PI_Q60;
                q[0] = 1'b1;
            end
        end
        return 32'((q + 1) >> 1);
    endfunction

    task automatic build_tables();
        logic [63:0] p;
        logic [63:0] n;
        logic [63:0] root;
        logic [63:0] b;
        p = 64'd1 << 62;
        for (int i = 0; i < STEPS; i++) begin
            atan_q32[i] = atan_turn_entry(i);
            p = p - p / ((64'd1 << (2 * i)) + 1);
        end
        // integer square root of the gain product
        n = p;
        root = '0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n = n - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        rot_start_x = longint'((root + (64'd1 << (30 - FRAC))) >> (31 - FRAC));
    endtask

    function automatic longint qmul(input longint a, input longint b);
        return (a * b + (longint'(1) << (FRAC - 1))) >>> FRAC;
    endfunction

    // 1e-7 degree to a q32 binary angle
    function automatic logic [31:0] binary_angle(input longint a);
        longint      t;
        logic [63:0] v;
        t = ((a % TURN_IN_E7) + TURN_IN_E7) % TURN_IN_E7;
        v = ((64'(t) << 28) + 64'd112500000) / 64'd225000000;
        return v[31:0];
    endfunction

    function automatic void rotate_unit(input logic [31:0] a, output longint c,
                                        output longint s);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     flip;
        x = rot_start_x;
        y = 0;
        // second and third quadrant: turn by half and negate at the end
        flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
        if (flip) a = a - HALF_TURN;
        z = longint'({32'd0, a});
        if (a >= HALF_TURN) z = z - (longint'(1) << 32);
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - longint'({32'd0, atan_q32[i]});
            end else begin
                x = x + dx; y = y - dy; z = z + longint'({32'd0, atan_q32[i]});
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic [31:0] vector_angle(input longint y, input longint x);
        logic [31:0] z;
        longint      dx;
        longint      dy;
        z = '0;
        if (x < 0) begin
            x = -x; y = -y; z = HALF_TURN;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx; y = y - dy; z = z + atan_q32[i];
            end else begin
                x = x - dx; y = y + dy; z = z - atan_q32[i];
            end
        end
        return z;
    endfunction

    function automatic logic [15:0] predict_bearing(input logic signed [30:0] lat1,
                                                    input logic signed [31:0] lon1,
                                                    input logic signed [30:0] lat2,
                                                    input logic signed [31:0] lon2);
        longint      c1, s1, c2, s2, cd, sd, num, den;
        logic [63:0] cent;
        rotate_unit(binary_angle(longint'(lat1)), c1, s1);
        rotate_unit(binary_angle(longint'(lat2)), c2, s2);
        rotate_unit(binary_angle(longint'(lon2) - longint'(lon1)), cd, sd);
        num = qmul(sd, c2);
        den = qmul(c1, s2) - qmul(s1, qmul(c2, cd));
        // zero vector gives north
        if (num == 0 && den == 0) return '0;
        cent = ({32'd0, vector_angle(num, den)} * 64'd36000 + (64'd1 << 31)) >> 32;
        // a full turn after rounding folds back to north
        if (cent >= 64'(CENT_TURN)) cent = '0;
        return cent[15:0];
    endfunction

    // ---------------------------------------------------------------------
    // stimulus side
    // ---------------------------------------------------------------------

    // valid stays high between back-to-back transfers, lowered only for a gap
    task automatic send_positions(input logic signed [30:0] lat1, input logic signed [31:0] lon1,
                                  input logic signed [30:0] lat2, input logic signed [31:0] lon2);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_start_lat <= lat1;
        i_start_lon <= lon1;
        i_end_lat   <= lat2;
        i_end_lon   <= lon2;
        do @(posedge i_clk); while (!o_ready);
        bearing_queue.push_back(predict_bearing(lat1, lon1, lat2, lon2));
    endtask

    function automatic logic signed [30:0] rand_lat();
        return 31'(longint'($urandom_range(0, 1800000000)) - 900000000);
    endfunction

    function automatic logic signed [31:0] rand_lon();
        return 32'(longint'($urandom_range(0, 2000000000)) * 9 / 5 - 1800000000);
    endfunction

    // corners of the field ranges, poles, antimeridian, same point
    task automatic test_extremes();
        send_positions(31'sd0, 32'sd0, 31'sd0, 32'sd0);
        send_positions(31'sd900000000, 32'sd0, 31'sd900000000, 32'sd1800000000);
        send_positions(-31'sd900000000, 32'sd0, 31'sd900000000, 32'sd0);
        send_positions(31'sd900000000, -32'sd1800000000, -31'sd900000000, 32'sd1800000000);
        send_positions(31'sd0, -32'sd1800000000, 31'sd0, 32'sd1800000000);
        send_positions(31'sd0, 32'sd1799999999, 31'sd0, -32'sd1800000000);
        send_positions(31'sd10, 32'sd0, 31'sd0, 32'sd0);
        send_positions(31'sd0, 32'sd0, 31'sd0, 32'sd1);
        send_positions(31'sd0, 32'sd0, -31'sd1, -32'sd1);
        send_positions(31'sd0, 32'sd0, -31'sd1, 32'sd0);
        send_positions(31'sd515000000, 32'sd0, 31'sd515000000, -32'sd10);
        // field bit patterns outside the nominal range, used as plain angles
        send_positions(31'h3FFF_FFFF, 32'h7FFF_FFFF, 31'h4000_0000, 32'h8000_0000);
        send_positions(31'h4000_0000, 32'h8000_0000, 31'h3FFF_FFFF, 32'h7FFF_FFFF);
        send_positions(-31'sd1, -32'sd1, -31'sd1, -32'sd1);
        send_positions(31'sd123456789, 32'sd987654321, 31'sd123456789, 32'sd987654321);
    endtask

    task automatic test_world_pairs(input int count);
        for (int n = 0; n < count; n++)
            send_positions(rand_lat(), rand_lon(), rand_lat(), rand_lon());
    endtask

    // short hops and near-identical points: tiny operands, near-north rounding
    task automatic test_short_hops(input int count);
        logic signed [30:0] lat;
        logic signed [31:0] lon;
        for (int n = 0; n < count; n++) begin
            lat = rand_lat();
            lon = rand_lon();
            send_positions(lat, lon, 31'(lat + $signed($urandom_range(0, 2000)) - 1000),
                           32'(lon + $signed($urandom_range(0, 2000)) - 1000));
        end
    endtask

    task automatic test_raw_bits(input int count);
        for (int n = 0; n < count; n++)
            send_positions(31'($urandom), $urandom, 31'($urandom), $urandom);
    endtask

    // ---------------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------------

    initial begin
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    logic [15:0] expected_bearing;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (bearing_queue.size() == 0) begin
                $display("%0t: unexpected transfer, bearing %0d", $time, o_bearing_centideg);
                failed = 1'b1;
            end else begin
                expected_bearing = bearing_queue.pop_front();
                if (o_bearing_centideg !== expected_bearing) begin
                    $display("%0t: bearing expected %0d actual %0d", $time,
                             expected_bearing, o_bearing_centideg);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        build_tables();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_extremes();
        test_world_pairs(700);
        test_short_hops(300);
        test_raw_bits(250);
        // last stretch runs with no idling on either side
        quiet = 1'b1;
        test_world_pairs(200);
        i_valid <= 1'b0;
        while (bearing_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 16) @(posedge i_clk);
        if (!failed) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
